// ----- src/aabb_frustum_cull_top_assert.svh -----
// Assertion macros shared by the frustum culling block.
// AFC_ASSERT is checked outside reset; AFC_ASSERT_ALWAYS is checked at every edge.
`ifndef AABB_FRUSTUM_CULL_TOP_ASSERT_SVH
`define AABB_FRUSTUM_CULL_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define AFC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("aabb_frustum_cull: assertion failed");
`define AFC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("aabb_frustum_cull: assertion failed");
`else
`define AFC_ASSERT(lbl, prop)
`define AFC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- src/afc_pkg.sv -----
`timescale 1ns / 1ps

package afc_pkg;

  // Plane registers that software can write, and the hard upper bound on planes.
  localparam int PLANE_REGS  = 6;
  localparam int PLANE_SLOTS = 8;
  localparam int PLANE_COUNT = 6;
  localparam int CELL_COUNT  = (PLANE_COUNT > PLANE_SLOTS) ? PLANE_SLOTS : PLANE_COUNT;

  localparam int CFG_DATA_W = 64;
  localparam int ADDR_W     = $clog2(8 * PLANE_REGS);
  localparam int IDX_W      = ADDR_W - 3;

  localparam int FIELD_W = 16;
  localparam int PROD_W  = 2 * FIELD_W;
  // 2*d + 2*r at a scale of 2^18 fits in 37 bits with margin.
  localparam int SUM_W   = 37;
  localparam int OFF_SHIFT = 14;

  typedef logic [PLANE_REGS-1:0][CFG_DATA_W-1:0] plane_arr_t;

  // center components are signed Q12.4, extents unsigned Q12.4
  typedef struct packed {
    logic [2:0][FIELD_W-1:0] center;
    logic [2:0][FIELD_W-1:0] extent;
  } box_t;

endpackage

// ----- src/aabb_frustum_cull_top.sv -----
`timescale 1ns / 1ps

// Six-plane culling of axis-aligned boxes.
// Input channel: in_valid / in_stall with the box center (signed Q12.4) and
// full extents (unsigned Q12.4) on in_center_* and in_extent_*. An item is
// taken at an edge where in_valid is high and in_stall is low.
// Result channel: out_valid / out_stall with out_visible, one result per item,
// in input order. out_visible is 0 when the box is fully outside some plane.
// Planes are written over the APB port, register i at byte address 8*i, each
// packing a, b, c (signed Q1.14) in bits 47:0 and the offset (Q12.4) in 63:48.
// Structure: one cell per plane, each two register stages deep (multiply, then sum and compare).
// Throughput: one item per cycle while out_stall is low; the cell multipliers are fully pipelined.
// A stall on the output holds the head item; cells behind it keep taking items
// until the chain has no empty stage left, then in_stall rises.
// Reset (rst_n low, synchronous) empties the chain and clears all planes to
// zero; a zero plane never culls, so every box is visible after reset.
module aabb_frustum_cull_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [afc_pkg::FIELD_W-1:0]    in_center_x,
  input  logic [afc_pkg::FIELD_W-1:0]    in_center_y,
  input  logic [afc_pkg::FIELD_W-1:0]    in_center_z,
  input  logic [afc_pkg::FIELD_W-1:0]    in_extent_x,
  input  logic [afc_pkg::FIELD_W-1:0]    in_extent_y,
  input  logic [afc_pkg::FIELD_W-1:0]    in_extent_z,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_visible,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [afc_pkg::ADDR_W-1:0]     paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import afc_pkg::*;

  plane_arr_t planes;

  logic                  valid_w [CELL_COUNT+1];
  logic                  ready_w [CELL_COUNT+1];
  box_t                  box_w   [CELL_COUNT+1];
  logic                  vis_w   [CELL_COUNT+1];

  afc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .planes  (planes)
  );

  assign valid_w[0] = in_valid;
  assign in_stall   = !ready_w[0];
  assign vis_w[0]   = 1'b1;
  assign box_w[0]   = '{center: {in_center_z, in_center_y, in_center_x},
                        extent: {in_extent_z, in_extent_y, in_extent_x}};

  for (genvar i = 0; i < CELL_COUNT; i++) begin : g_cell
    logic [CFG_DATA_W-1:0] plane;

    // slots past the writable registers stay zero and never cull
    if (i < PLANE_REGS) begin : g_reg
      assign plane = planes[i];
    end else begin : g_zero
      assign plane = '0;
    end

    afc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (plane),
      .up_valid (valid_w[i]),
      .up_ready (ready_w[i]),
      .up_box   (box_w[i]),
      .up_vis   (vis_w[i]),
      .dn_valid (valid_w[i+1]),
      .dn_ready (ready_w[i+1]),
      .dn_box   (box_w[i+1]),
      .dn_vis   (vis_w[i+1])
    );
  end

  assign out_valid          = valid_w[CELL_COUNT];
  assign out_visible        = vis_w[CELL_COUNT];
  assign ready_w[CELL_COUNT] = !out_stall;

  `include "aabb_frustum_cull_top_assert.svh"

  `AFC_ASSERT(a_empty_head_ready, !out_valid |-> !in_stall)
  `AFC_ASSERT(a_head_hold, (out_valid && out_stall) |=> (out_valid && $stable(box_w[CELL_COUNT])))
  `AFC_ASSERT_ALWAYS(a_pready_high, pready)

endmodule

// ----- src/afc_regs.sv -----
`timescale 1ns / 1ps

module afc_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [afc_pkg::ADDR_W-1:0] paddr,
  input  logic [afc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [afc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                      pready,
  output afc_pkg::plane_arr_t       planes
);
  import afc_pkg::*;

  plane_arr_t        plane_r;
  logic [IDX_W-1:0]  idx;
  logic              idx_ok;
  logic              wr_en;

  assign idx    = paddr[ADDR_W-1:3];
  assign idx_ok = (int'(idx) < PLANE_REGS);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign planes = plane_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= '0;
    end else if (wr_en && idx_ok) begin
      plane_r[idx] <= pwdata;
    end
  end

  always_comb begin
    prdata = '0;
    if (idx_ok) begin
      prdata = plane_r[idx];
    end
  end

endmodule

// ----- src/afc_cell.sv -----
`timescale 1ns / 1ps

module afc_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [afc_pkg::CFG_DATA_W-1:0] plane,
  input  logic                           up_valid,
  output logic                           up_ready,
  input  afc_pkg::box_t                  up_box,
  input  logic                           up_vis,
  output logic                           dn_valid,
  input  logic                           dn_ready,
  output afc_pkg::box_t                  dn_box,
  output logic                           dn_vis
);
  import afc_pkg::*;

  logic [2:0][FIELD_W-1:0] nrm;
  logic [2:0][FIELD_W-1:0] nabs;
  logic [2:0][PROD_W-1:0]  prod_d;
  logic [2:0][PROD_W-1:0]  prod_r;

  // stage A: products
  logic                    valid_a_r;
  box_t                    box_a_r;
  logic                    vis_a_r;
  logic [2:0][PROD_W-1:0]  pd_r;
  logic [2:0][PROD_W-1:0]  pr_r;

  // stage B: plane decision
  logic                    valid_b_r;
  box_t                    box_b_r;
  logic                    vis_b_r;

  logic                    ready_a;
  logic                    ready_b;
  logic signed [SUM_W-1:0] d2;
  logic        [SUM_W-1:0] r2;
  logic signed [SUM_W-1:0] test;
  logic                    outside;

  assign nrm = plane[3*FIELD_W-1:0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nabs[k]   = nrm[k][FIELD_W-1] ? (~nrm[k] + FIELD_W'(1)) : nrm[k];
      prod_d[k] = PROD_W'($signed(nrm[k]) * $signed(up_box.center[k]));
      prod_r[k] = PROD_W'(nabs[k]) * PROD_W'(up_box.extent[k]);
    end
  end

  assign ready_b  = !valid_b_r || dn_ready;
  assign ready_a  = !valid_a_r || ready_b;
  assign up_ready = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (ready_a) begin
      valid_a_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && ready_a) begin
      box_a_r <= up_box;
      vis_a_r <= up_vis;
      pd_r    <= prod_d;
      pr_r    <= prod_r;
    end
  end

  // 2*d + 2*r < 0 means the box lies fully outside this plane
  always_comb begin
    d2 = SUM_W'($signed(plane[CFG_DATA_W-1:3*FIELD_W])) <<< OFF_SHIFT;
    r2 = '0;
    for (int k = 0; k < 3; k++) begin
      d2 = d2 + SUM_W'($signed(pd_r[k]));
      r2 = r2 + SUM_W'(pr_r[k]);
    end
    test    = (d2 <<< 1) + $signed(r2);
    outside = test[SUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_b_r <= 1'b0;
    end else if (ready_b) begin
      valid_b_r <= valid_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_a_r && ready_b) begin
      box_b_r <= box_a_r;
      vis_b_r <= vis_a_r && !outside;
    end
  end

  assign dn_valid = valid_b_r;
  assign dn_box   = box_b_r;
  assign dn_vis   = vis_b_r;

  `include "aabb_frustum_cull_top_assert.svh"

  `AFC_ASSERT(a_cull_sticky, (valid_a_r && ready_b && !vis_a_r) |=> !vis_b_r)
  `AFC_ASSERT(a_stage_hold, (valid_b_r && !dn_ready) |=> (valid_b_r && $stable(vis_b_r)))
  `AFC_ASSERT(a_empty_ready, !valid_a_r |-> up_ready)

endmodule
